FILE: design/dcc_lpb_pkg.sv
// Package for the DCC locomotive packet builder.
// Item types, the job handed from scheduler to serializer, and DCC codes.
// No dependencies.
package dcc_lpb_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_LOCO_ADDRESS        = 2'd0;
    localparam logic [1:0] REG_SPEED_REFRESH_US    = 2'd1;
    localparam logic [1:0] REG_FUNCTION_REFRESH_US = 2'd2;

    localparam int CFG_DATA_BITS = 32;
    localparam int ADDR_BITS     = 14;

    // Reset values of the configuration registers
    localparam logic [ADDR_BITS-1:0]     LOCO_ADDRESS_RST        = 14'd3;
    localparam logic [CFG_DATA_BITS-1:0] SPEED_REFRESH_US_RST    = 32'd100000;
    localparam logic [CFG_DATA_BITS-1:0] FUNCTION_REFRESH_US_RST = 32'd60000000;

    // DCC codes
    localparam logic [ADDR_BITS-1:0] SHORT_ADDR_MAX   = 14'd127;
    localparam logic [1:0]           LONG_ADDR_PREFIX = 2'b11;   // 0xC0
    localparam logic [7:0]           CMD_SPEED_128    = 8'h3F;
    localparam logic [7:0]           ESTOP_BYTE       = 8'h01;
    localparam logic [6:0]           SPEED_STEP_MAX   = 7'd126;
    localparam logic [2:0]           GRP1_PREFIX      = 3'b100;  // 0x80
    localparam logic [3:0]           GRP2_PREFIX      = 4'hB;
    localparam logic [3:0]           GRP3_PREFIX      = 4'hA;
    localparam logic [7:0]           CMD_F13_F20      = 8'hDE;
    localparam logic [7:0]           CMD_F21_F28      = 8'hDF;

    // Input item
    typedef struct packed {
        logic               force_req;
        logic [47:0]        now_us;
        logic signed [7:0]  speed;
        logic               direction;
        logic [28:0]        function_bits;
        logic               queue_near_full;
    } req_item_t;

    // Result item: one packet byte
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       packet_end;
        logic       run_last;
    } pkt_item_t;

    // Packet currently being sent
    typedef enum logic [2:0] {
        PKT_SPEED,
        PKT_GRP1,
        PKT_GRP2,
        PKT_GRP3,
        PKT_GRP4,
        PKT_GRP5
    } pkt_sel_t;

    // Work for one request, decided at accept time
    typedef struct packed {
        logic                 speed_due;
        logic                 func_due;
        logic                 long_addr;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           speed_byte;
        logic [28:0]          fbits;
    } job_t;

endpackage

FILE: design/dcc_lpb_sched.sv
// Scheduler: configuration registers, speed/function timestamps and the
// per-request decision of which packets go out. Uses dcc_lpb_pkg.
module dcc_lpb_sched
    import dcc_lpb_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  req_item_t                req,
    input  logic                     take,
    output job_t                     job,
    output logic                     job_valid
);

    localparam int NOW_BITS = (TIME_BITS < 48) ? TIME_BITS : 48;

    logic [ADDR_BITS-1:0]     loco_address_reg;
    logic [CFG_DATA_BITS-1:0] speed_refresh_reg;
    logic [CFG_DATA_BITS-1:0] function_refresh_reg;
    logic [TIME_BITS-1:0]     last_speed_reg, last_speed_next;
    logic [TIME_BITS-1:0]     last_func_reg,  last_func_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS:0]   speed_limit;
    logic [TIME_BITS:0]   func_limit;
    logic                 speed_elapsed;
    logic                 func_elapsed;
    logic [6:0]           step_sat;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loco_address_reg     <= LOCO_ADDRESS_RST;
            speed_refresh_reg    <= SPEED_REFRESH_US_RST;
            function_refresh_reg <= FUNCTION_REFRESH_US_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOCO_ADDRESS:        loco_address_reg     <= cfg_data[ADDR_BITS-1:0];
                REG_SPEED_REFRESH_US:    speed_refresh_reg    <= cfg_data;
                REG_FUNCTION_REFRESH_US: function_refresh_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Elapsed tests: now > last + period, sum kept one bit wider
    always_comb
    begin
        now_t         = TIME_BITS'(req.now_us[NOW_BITS-1:0]);
        speed_limit   = {1'b0, last_speed_reg} + (TIME_BITS+1)'(speed_refresh_reg);
        func_limit    = {1'b0, last_func_reg} + (TIME_BITS+1)'(function_refresh_reg);
        speed_elapsed = {1'b0, now_t} > speed_limit;
        func_elapsed  = {1'b0, now_t} > func_limit;
    end

    // Job for the serializer
    always_comb
    begin
        step_sat = (req.speed[6:0] > SPEED_STEP_MAX) ? SPEED_STEP_MAX : req.speed[6:0];
        job.speed_due = req.force_req || speed_elapsed;
        job.func_due  = !req.force_req && !req.queue_near_full && func_elapsed;
        job.long_addr = loco_address_reg > SHORT_ADDR_MAX;
        job.addr      = loco_address_reg;
        job.fbits     = req.function_bits;
        if (req.speed[7])
            job.speed_byte = ESTOP_BYTE;
        else
            job.speed_byte = {req.direction, (step_sat == 7'd0) ? 7'd0 : step_sat + 7'd1};
        job_valid = job.speed_due || job.func_due;
    end

    // Timestamp updates on accepted items: the function time on every one, the speed time only when speed is due
    always_comb
    begin
        last_speed_next = last_speed_reg;
        last_func_next  = last_func_reg;
        if (take)
        begin
            last_func_next = now_t;
            if (job.speed_due)
                last_speed_next = now_t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_speed_reg <= '0;
            last_func_reg  <= '0;
        end
        else
        begin
            last_speed_reg <= last_speed_next;
            last_func_reg  <= last_func_next;
        end
    end

endmodule

FILE: design/dcc_lpb_serializer.sv
// Serializer: holds one job and sends its packet bytes one per cycle while
// the output is not stalled, through an output register. Uses dcc_lpb_pkg.
module dcc_lpb_serializer
    import dcc_lpb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    output logic      take,
    input  job_t      new_job,
    input  logic      new_job_valid,
    output logic      pkt_valid,
    input  logic      pkt_stall,
    output pkt_item_t pkt
);

    job_t      job_reg,       job_next;
    logic      job_valid_reg, job_valid_next;
    pkt_sel_t  sel_reg,       sel_next;
    logic [1:0] pos_reg,      pos_next;
    pkt_item_t out_reg,       out_next;
    logic      out_valid_reg, out_valid_next;

    logic [1:0] addr_len;
    logic [1:0] body_len;
    logic [2:0] pkt_len;
    logic [1:0] body_idx;
    logic [7:0] cur_byte;
    logic       cur_end;
    logic       cur_last;
    logic       out_free;
    logic       move;

    // Current byte of the current packet
    always_comb
    begin
        addr_len = job_reg.long_addr ? 2'd2 : 2'd1;
        case (sel_reg)
            PKT_SPEED, PKT_GRP4, PKT_GRP5: body_len = 2'd2;
            default:                       body_len = 2'd1;
        endcase
        pkt_len  = {1'b0, addr_len} + {1'b0, body_len};
        body_idx = pos_reg - addr_len;
        cur_byte = 8'h00;
        if (pos_reg < addr_len)
        begin
            if (job_reg.long_addr && pos_reg == 2'd0)
                cur_byte = {LONG_ADDR_PREFIX, job_reg.addr[13:8]};
            else
                cur_byte = job_reg.addr[7:0];
        end
        else
        begin
            case (sel_reg)
                PKT_SPEED: cur_byte = (body_idx == 2'd0) ? CMD_SPEED_128 : job_reg.speed_byte;
                PKT_GRP1:  cur_byte = {GRP1_PREFIX, job_reg.fbits[0], job_reg.fbits[4:1]};
                PKT_GRP2:  cur_byte = {GRP2_PREFIX, job_reg.fbits[8:5]};
                PKT_GRP3:  cur_byte = {GRP3_PREFIX, job_reg.fbits[12:9]};
                PKT_GRP4:  cur_byte = (body_idx == 2'd0) ? CMD_F13_F20 : job_reg.fbits[20:13];
                PKT_GRP5:  cur_byte = (body_idx == 2'd0) ? CMD_F21_F28 : job_reg.fbits[28:21];
                default:   cur_byte = 8'h00;
            endcase
        end
        cur_end  = {1'b0, pos_reg} == (pkt_len - 3'd1);
        cur_last = cur_end &&
                   (sel_reg == PKT_GRP5 || (sel_reg == PKT_SPEED && !job_reg.func_due));
    end

    // Handshake: a new item enters as the last byte of the old one leaves
    always_comb
    begin
        out_free  = !out_valid_reg || !pkt_stall;
        move      = job_valid_reg && out_free;
        req_stall = job_valid_reg && !(out_free && cur_last);
        take      = req_valid && !req_stall;
    end

    // Job sequencing
    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        sel_next       = sel_reg;
        pos_next       = pos_reg;
        if (take)
        begin
            job_next       = new_job;
            job_valid_next = new_job_valid;
            sel_next       = new_job.speed_due ? PKT_SPEED : PKT_GRP1;
            pos_next       = 2'd0;
        end
        else if (move)
        begin
            if (cur_last)
                job_valid_next = 1'b0;
            if (cur_end)
            begin
                pos_next = 2'd0;
                case (sel_reg)
                    PKT_SPEED: sel_next = PKT_GRP1;
                    PKT_GRP1:  sel_next = PKT_GRP2;
                    PKT_GRP2:  sel_next = PKT_GRP3;
                    PKT_GRP3:  sel_next = PKT_GRP4;
                    PKT_GRP4:  sel_next = PKT_GRP5;
                    default:   sel_next = PKT_SPEED;
                endcase
            end
            else
                pos_next = pos_reg + 2'd1;
        end
    end

    // Output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next       = move;
            out_next.packet_byte = cur_byte;
            out_next.packet_end  = cur_end;
            out_next.run_last    = cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            sel_reg       <= PKT_SPEED;
            pos_reg       <= 2'd0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    assign pkt_valid = out_valid_reg;
    assign pkt       = out_reg;

    // Checks
    a_pos_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> ({1'b0, pos_reg} < pkt_len))
        else $error("byte position past end of packet");

    a_empty_job_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !new_job_valid) |=> !job_valid_reg)
        else $error("item with no packets left a job behind");

    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.run_last) |-> out_reg.packet_end)
        else $error("run ended inside a packet");

    a_no_take_midrun: assert property (@(posedge clk) disable iff (!rst_n)
        (take && job_valid_reg) |-> (move && cur_last))
        else $error("new item taken while a run was still sending");

endmodule

FILE: design/dcc_loco_packet_builder_unit.sv
// Top level of the DCC locomotive packet builder.
// Instantiates dcc_lpb_sched and dcc_lpb_serializer; uses dcc_lpb_pkg.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_item_t request
//  pkt     | out       | pkt_valid/pkt_stall | pkt_item_t, one packet byte
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// A request produces 0 to 21 packet bytes (speed packet 3-4, group packets
// 2-4 each, depending on address length); a request with no packet due
// leaves no job in the serializer. The next request is taken in the cycle
// the last byte of the previous one moves to the output register. Reset is
// immediate, with no clearing pass. A stalled output holds its byte; while a
// job is held, the serializer then stalls requests.
module dcc_loco_packet_builder_unit
    import dcc_lpb_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  req_item_t                req,
    output logic                     pkt_valid,
    input  logic                     pkt_stall,
    output pkt_item_t                pkt
);

    job_t job;
    logic job_valid;
    logic take;

    // Decision and timestamps
    dcc_lpb_sched #(
        .TIME_BITS (TIME_BITS)
    ) u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .take      (take),
        .job       (job),
        .job_valid (job_valid)
    );

    // Byte sequencing and output register
    dcc_lpb_serializer u_serializer (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .take          (take),
        .new_job       (job),
        .new_job_valid (job_valid),
        .pkt_valid     (pkt_valid),
        .pkt_stall     (pkt_stall),
        .pkt           (pkt)
    );

endmodule

FILE: tb/sv/dcc_packet_checker.sv
// Checker for the DCC locomotive packet builder: watches the config port and both
// channels, predicts the packet bytes of each request and compares them in order.
// Depends on dcc_lpb_pkg.
module dcc_packet_checker
    import dcc_lpb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     req_valid,
    input  logic                     req_stall,
    input  req_item_t                req,
    input  logic                     pkt_valid,
    input  logic                     pkt_stall,
    input  pkt_item_t                pkt,
    output int                       fail_count,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the registers and timestamps
    logic [ADDR_BITS-1:0]     loco_addr;
    logic [CFG_DATA_BITS-1:0] speed_period;
    logic [CFG_DATA_BITS-1:0] func_period;
    logic [47:0]              speed_time;
    logic [47:0]              func_time;

    pkt_item_t run_bytes[$];   // bytes of the request being predicted
    pkt_item_t due_bytes[$];   // bytes still owed by the block
    pkt_item_t want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Strictly greater gap, no wrap; a clock that went backward never counts
    function automatic logic period_passed(logic [47:0] t_now, logic [47:0] t_last,
                                           logic [31:0] period);
        logic [63:0] gap;
        if (t_now < t_last)
            return 1'b0;
        gap = {16'd0, t_now - t_last};
        return gap > {32'd0, period};
    endfunction

    function automatic void add_byte(logic [7:0] value, logic last_of_packet);
        pkt_item_t b;
        b.packet_byte = value;
        b.packet_end  = last_of_packet;
        b.run_last    = 1'b0;
        run_bytes.insert(run_bytes.size(), b);
    endfunction

    // Short address is one byte, long address two
    function automatic void add_address();
        if (loco_addr > SHORT_ADDR_MAX)
            add_byte({LONG_ADDR_PREFIX, loco_addr[13:8]}, 1'b0);
        add_byte(loco_addr[7:0], 1'b0);
    endfunction

    function automatic void build_packets(req_item_t r);
        logic [7:0]  step;
        logic [7:0]  speed_code;
        logic [28:0] fb;
        pkt_item_t   tail;
        run_bytes.delete();
        fb = r.function_bits;

        // Speed packet: forced or refresh period expired
        if (r.force_req || period_passed(r.now_us, speed_time, speed_period))
        begin
            add_address();
            add_byte(CMD_SPEED_128, 1'b0);
            step = r.speed;
            if (step[7])
                speed_code = ESTOP_BYTE;   // any negative step is an e-stop
            else
            begin
                if (step > {1'b0, SPEED_STEP_MAX})
                    step = {1'b0, SPEED_STEP_MAX};
                speed_code = {r.direction, (step == 8'd0) ? 7'd0 : step[6:0] + 7'd1};
            end
            add_byte(speed_code, 1'b1);
            speed_time = r.now_us;
        end

        // All five function groups
        if (!r.force_req && !r.queue_near_full &&
            period_passed(r.now_us, func_time, func_period))
        begin
            add_address();
            add_byte({GRP1_PREFIX, fb[0], fb[4:1]}, 1'b1);
            add_address();
            add_byte({GRP2_PREFIX, fb[8:5]}, 1'b1);
            add_address();
            add_byte({GRP3_PREFIX, fb[12:9]}, 1'b1);
            add_address();
            add_byte(CMD_F13_F20, 1'b0);
            add_byte(fb[20:13], 1'b1);
            add_address();
            add_byte(CMD_F21_F28, 1'b0);
            add_byte(fb[28:21], 1'b1);
        end
        func_time = r.now_us;

        if (run_bytes.size() != 0)
        begin
            tail = run_bytes.pop_back();
            tail.run_last = 1'b1;
            run_bytes.insert(run_bytes.size(), tail);
        end
        foreach (run_bytes[i])
            due_bytes.insert(due_bytes.size(), run_bytes[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loco_addr    = LOCO_ADDRESS_RST;
            speed_period = SPEED_REFRESH_US_RST;
            func_period  = FUNCTION_REFRESH_US_RST;
            speed_time   = '0;
            func_time    = '0;
            due_bytes.delete();
        end
        else
        begin
            // Register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOCO_ADDRESS:        loco_addr    = cfg_data[ADDR_BITS-1:0];
                    REG_SPEED_REFRESH_US:    speed_period = cfg_data;
                    REG_FUNCTION_REFRESH_US: func_period  = cfg_data;
                    default: ;
                endcase
            end

            // Outgoing byte against the oldest prediction
            if (pkt_valid && !pkt_stall)
            begin
                if (due_bytes.size() == 0)
                begin
                    $error("unexpected packet item: packet_byte %02h packet_end %0b run_last %0b",
                           pkt.packet_byte, pkt.packet_end, pkt.run_last);
                    fail_count++;
                end
                else
                begin
                    want = due_bytes.pop_front();
                    if (pkt.packet_byte !== want.packet_byte)
                    begin
                        $error("packet_byte: expected %02h, got %02h",
                               want.packet_byte, pkt.packet_byte);
                        fail_count++;
                    end
                    if (pkt.packet_end !== want.packet_end)
                    begin
                        $error("packet_end: expected %0b, got %0b",
                               want.packet_end, pkt.packet_end);
                        fail_count++;
                    end
                    if (pkt.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, pkt.run_last);
                        fail_count++;
                    end
                end
            end

            // Accepted request
            if (req_valid && !req_stall)
                build_packets(req);
        end
        pending = due_bytes.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the DCC locomotive packet builder testbench: clock, reset, request and
// register stimulus, output stall pattern and the verdict.
// Depends on dcc_lpb_pkg, dcc_loco_packet_builder_unit and dcc_packet_checker.
module tb_top;
    import dcc_lpb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [1:0]               cfg_index = REG_LOCO_ADDRESS;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     req_valid = 1'b0;
    logic                     req_stall;
    req_item_t                req = '0;
    logic                     pkt_valid;
    logic                     pkt_stall = 1'b0;
    pkt_item_t                pkt;

    int fail_count;
    int pending;

    // Stimulus state
    logic [47:0] cur_time = '0;
    logic [31:0] spd_per = SPEED_REFRESH_US_RST;
    logic [31:0] fn_per = FUNCTION_REFRESH_US_RST;
    int          burst_left = 0;
    int          gap_max = 0;
    int          stall_pct = 0;
    int          stall_len = 0;
    int          stall_cnt = 0;

    dcc_loco_packet_builder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt)
    );

    dcc_packet_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .pkt_valid  (pkt_valid),
        .pkt_stall  (pkt_stall),
        .pkt        (pkt),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: stall runs of random length, started at a per-phase rate
    always @(posedge clk)
    begin
        if (stall_cnt != 0)
        begin
            pkt_stall <= 1'b1;
            stall_cnt <= stall_cnt - 1;
        end
        else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            pkt_stall <= 1'b1;
            stall_cnt <= $urandom_range(0, stall_len);
        end
        else
            pkt_stall <= 1'b0;
    end

    function automatic req_item_t make_req(logic f, logic [47:0] t, logic signed [7:0] s,
                                           logic d, logic [28:0] fb, logic q);
        req_item_t r;
        r.force_req       = f;
        r.now_us          = t;
        r.speed           = s;
        r.direction       = d;
        r.function_bits   = fb;
        r.queue_near_full = q;
        return r;
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return $urandom_range(1, 50);
            2:       return $urandom_range(1000, 2000000);
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Time steps are tiny or straddle one of the two refresh periods; some jump anywhere
    function automatic req_item_t random_req();
        req_item_t   r;
        logic [63:0] d;
        case ($urandom_range(0, 9))
            0, 1, 2: d = 64'($urandom_range(0, 3));
            3, 4:    d = {32'd0, spd_per} + 64'($urandom_range(0, 2));
            5, 6:    d = {32'd0, fn_per} + 64'($urandom_range(0, 2));
            7:       d = {32'd0, $urandom};
            8:       d = {$urandom, $urandom} - {16'd0, cur_time};
            default: d = 64'($urandom_range(0, 1000000));
        endcase
        cur_time = cur_time + d[47:0];
        r.now_us = cur_time;
        case ($urandom_range(0, 7))
            0:       r.speed = -8'sd1;
            1:       r.speed = 8'($urandom_range(0, 255));
            default: r.speed = 8'($urandom_range(0, 126));
        endcase
        r.force_req       = ($urandom_range(0, 99) < 15);
        r.queue_near_full = ($urandom_range(0, 99) < 20);
        r.direction       = 1'($urandom_range(0, 1));
        r.function_bits   = 29'($urandom_range(0, 29'h1FFF_FFFF));
        return r;
    endfunction

    // Sender works in bursts with random gaps between them
    task automatic send_req(req_item_t it);
        if (burst_left == 0)
        begin
            if (gap_max != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Drain all owed bytes, then leave room for a request with no bytes
    task automatic settle();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(logic [ADDR_BITS-1:0] addr, logic [31:0] sp, logic [31:0] fp);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOCO_ADDRESS;
        cfg_data  <= {{(CFG_DATA_BITS-ADDR_BITS){1'b0}}, addr};
        @(posedge clk);
        cfg_index <= REG_SPEED_REFRESH_US;
        cfg_data  <= sp;
        @(posedge clk);
        cfg_index <= REG_FUNCTION_REFRESH_US;
        cfg_data  <= fp;
        @(posedge clk);
        cfg_we <= 1'b0;
        spd_per = sp;
        fn_per  = fp;
    endtask

    initial
    begin
        int                   phase;
        int                   n;
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          sp;
        logic [31:0]          fp;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset settings (short address 3)
        gap_max   = 3;
        stall_pct <= 30;
        stall_len <= 4;
        send_req(make_req(1'b1, 48'd0, 8'sd0, 1'b1, 29'd0, 1'b0));
        send_req(make_req(1'b1, 48'd0, -8'sd1, 1'b1, 29'h1FFF_FFFF, 1'b0));
        send_req(make_req(1'b1, 48'd0, 8'sd127, 1'b1, 29'd0, 1'b0));
        send_req(make_req(1'b1, 48'd0, -8'sd128, 1'b0, 29'd0, 1'b0));
        send_req(make_req(1'b1, 48'd0, 8'sd126, 1'b0, 29'd0, 1'b1));
        // exactly one period later: nothing due
        send_req(make_req(1'b0, 48'd100000, 8'sd5, 1'b1, 29'd0, 1'b0));
        send_req(make_req(1'b0, 48'd100001, 8'sd5, 1'b1, 29'd0, 1'b0));
        // function groups due but queue near full
        send_req(make_req(1'b0, 48'd60100002, 8'sd64, 1'b0, 29'h1FFF_FFFF, 1'b1));
        send_req(make_req(1'b0, 48'd120100003, 8'sd64, 1'b0, 29'h1FFF_FFFF, 1'b0));
        // force suppresses function groups
        send_req(make_req(1'b1, 48'd240200010, 8'sd1, 1'b1, 29'h1FFF_FFFF, 1'b0));
        // clock going backward
        send_req(make_req(1'b0, 48'd240200009, 8'sd1, 1'b1, 29'h1FFF_FFFF, 1'b0));
        send_req(make_req(1'b0, 48'hFFFF_FFFF_FFFF, 8'sd1, 1'b0, 29'h1555_5555, 1'b0));
        send_req(make_req(1'b0, 48'd0, 8'sd1, 1'b0, 29'h1555_5555, 1'b0));
        send_req(make_req(1'b1, 48'd0, -8'sd1, 1'b0, 29'h0AAA_AAAA, 1'b0));

        // Broadcast address, zero periods
        settle();
        write_config(14'd0, 32'd0, 32'd0);
        send_req(make_req(1'b0, 48'd1, 8'sd100, 1'b1, 29'h0AAA_AAAA, 1'b0));
        send_req(make_req(1'b0, 48'd1, 8'sd100, 1'b1, 29'h0AAA_AAAA, 1'b0));
        send_req(make_req(1'b0, 48'd2, 8'sd2, 1'b0, 29'h1555_5555, 1'b0));

        // Highest long address
        settle();
        write_config(14'd10239, 32'd0, 32'd0);
        send_req(make_req(1'b0, 48'd3, 8'sd126, 1'b1, 29'h1FFF_FFFF, 1'b0));
        send_req(make_req(1'b0, 48'd4, -8'sd1, 1'b1, 29'd0, 1'b0));
        cur_time = 48'd4;

        // Random phases, each with its own settings and idle pattern
        for (phase = 0; phase < 10; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    addr = 14'd0;
                    sp   = 32'd0;
                    fp   = 32'd0;
                end
                1:
                begin
                    addr = 14'd10239;
                    sp   = 32'hFFFF_FFFF;
                    fp   = 32'hFFFF_FFFF;
                end
                2:
                begin
                    addr = 14'd127;
                    sp   = 32'd1;
                    fp   = 32'd2;
                end
                3:
                begin
                    addr = 14'd128;
                    sp   = SPEED_REFRESH_US_RST;
                    fp   = FUNCTION_REFRESH_US_RST;
                end
                default:
                begin
                    addr = 14'($urandom_range(0, 10239));
                    sp   = pick_period();
                    fp   = pick_period();
                end
            endcase
            write_config(addr, sp, fp);
            gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(2, 25);
            stall_pct <= (phase % 4 == 1) ? 0 : $urandom_range(10, 60);
            stall_len <= $urandom_range(0, 20);
            for (n = 0; n < 50; n++)
                send_req(random_req());
        end

        settle();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[dcc_loco_packet_builder_unit] OK");
        else
            $display("[dcc_loco_packet_builder_unit] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40ms;
        $display("[dcc_loco_packet_builder_unit] ERROR");
        $finish;
    end

endmodule
